// ===== hw/rtl/lnds_pkg.sv =====
// ============================================================================
// lnds_pkg
// Shared widths, defaults and controller/datapath command and status types
// for the longest non-decreasing subsequence block.
// ============================================================================
package lnds_pkg;

  // Default node store depth (longest sequence held)
  localparam int unsigned MAX_LEN_DEF = 64;
  // Width of counts and of the seq_length field
  localparam int unsigned CNT_W = 7;
  // Width of one sequence value
  localparam int unsigned VAL_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // latch input beat, clear piles on start
    logic pt_rd_mid;   // read pile top at the search midpoint
    logic nv_rd;       // read node value/link at the pile top just read
    logic cmp_step;    // narrow the search window
    logic pt_rd_link;  // read pile top left of the found pile
    logic commit;      // write node, update pile top and counts
    logic pt_rd_last;  // read top of the last pile, arm the chain walk
    logic walk_step;   // store one chain element, follow its link
    logic emit_step;   // fetch one element into the output register
    logic ovf_load;    // load the overflow result
  } lnds_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;         // incoming beat would be dropped
    logic search_open;  // search window not yet empty
    logic walk_end;     // current chain element is the first one
    logic emit_last;    // element being fetched ends the run
  } lnds_sts_t;

endpackage

// ===== hw/rtl/lnds_if.sv =====
// ============================================================================
// lnds_if
// Valid/ready channels of the longest non-decreasing subsequence block:
// input beats (start_new, value) and result beats (element, seq_length,
// last, overflow).
// ============================================================================
interface lnds_in_if import lnds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    start_new;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output start_new, output value, input ready);
  modport sink   (input valid, input start_new, input value, output ready);
endinterface

interface lnds_out_if import lnds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] element;
  logic [CNT_W-1:0]        seq_length;
  logic                    last;
  logic                    overflow;

  modport source (output valid, output element, output seq_length, output last,
                  output overflow, input ready);
  modport sink   (input valid, input element, input seq_length, input last,
                  input overflow, output ready);
endinterface

// ===== hw/rtl/longest_nondecreasing_subsequence.sv =====
// ============================================================================
// longest_nondecreasing_subsequence
// Streaming longest non-decreasing subsequence by patience sorting.
// ============================================================================
// Input channel in_i carries one sequence value per beat; start_new = 1
// empties the piles before that value is taken. After each value the block
// sends the longest non-decreasing subsequence of the prefix so far on
// out_o, one element per beat in ascending order, with seq_length (pile
// count) on every beat and last on the final one. A value that finds the
// node store full (MAX_LEN nodes, no start_new) is dropped and answered by
// a single beat with overflow = 1, element = 0 and last = 1.
// One item at a time: after accept comes a binary search over the piles
// before it (each probe reads the pile top table and then the node
// store), a commit that writes the node, the read of the last pile top
// that starts the chain walk, the walk (one node store read per element)
// and the emission of the elements while the sink is ready. An overflow
// beat is loaded once the output register is free.
// A stalled sink holds the output register and the emission; the next
// item is accepted once the final beat of a run is in the output register.
// Reset empties the piles; the stores need no clearing.
// ============================================================================
module longest_nondecreasing_subsequence import lnds_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lnds_in_if.sink     in_i,
  lnds_out_if.source  out_o
);

  lnds_cmd_t cmd;
  lnds_sts_t sts;

  // Sequencing
  lnds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic
  lnds_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_start_new_i   (in_i.start_new),
    .in_value_i       (in_i.value),
    .out_element_o    (out_o.element),
    .out_seq_length_o (out_o.seq_length),
    .out_last_o       (out_o.last),
    .out_overflow_o   (out_o.overflow)
  );

endmodule

// ===== hw/rtl/lnds_ctrl.sv =====
// ============================================================================
// lnds_ctrl
// Controller state machine: sequences the binary search, node commit,
// chain walk and result emission, and owns the output valid flag.
// ============================================================================
module lnds_ctrl import lnds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lnds_sts_t sts_i,
  output lnds_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_OVF      = 11'b000_0000_0010,
    ST_SRCH     = 11'b000_0000_0100,
    ST_SRCH_NV  = 11'b000_0000_1000,
    ST_SRCH_CMP = 11'b000_0001_0000,
    ST_COMMIT   = 11'b000_0010_0000,
    ST_WALK_PT  = 11'b000_0100_0000,
    ST_WALK_NV  = 11'b000_1000_0000,
    ST_WALK     = 11'b001_0000_0000,
    ST_EMIT     = 11'b010_0000_0000,
    ST_SPARE    = 11'b100_0000_0000
  } lnds_state_e;

  lnds_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // Output register can take a new beat this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.full ? ST_OVF : ST_SRCH;
        end
      end
      ST_OVF: begin
        if (out_free) begin
          cmd_o.ovf_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SRCH: begin
        if (sts_i.search_open) begin
          cmd_o.pt_rd_mid = 1'b1;
          state_d         = ST_SRCH_NV;
        end else begin
          cmd_o.pt_rd_link = 1'b1;
          state_d          = ST_COMMIT;
        end
      end
      ST_SRCH_NV: begin
        cmd_o.nv_rd = 1'b1;
        state_d     = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        cmd_o.cmp_step = 1'b1;
        state_d        = ST_SRCH;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_WALK_PT;
      end
      ST_WALK_PT: begin
        cmd_o.pt_rd_last = 1'b1;
        state_d          = ST_WALK_NV;
      end
      ST_WALK_NV: begin
        cmd_o.nv_rd = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit_step || cmd_o.ovf_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/lnds_dp.sv =====
// ============================================================================
// lnds_dp
// Datapath: pile top table, node store, reverse buffer, search window,
// counters and the result output register.
// ============================================================================
module lnds_dp import lnds_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lnds_cmd_t               cmd_i,
  output lnds_sts_t               sts_o,
  input  logic                    in_start_new_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  output logic signed [VAL_W-1:0] out_element_o,
  output logic [CNT_W-1:0]        out_seq_length_o,
  output logic                    out_last_o,
  output logic                    out_overflow_o
);

  localparam int unsigned IDX_W = $clog2(MAX_LEN);

  // Storage
  logic [IDX_W-1:0]        pt_mem [MAX_LEN];
  logic signed [VAL_W-1:0] nv_mem [MAX_LEN];
  logic [IDX_W:0]          bl_mem [MAX_LEN];  // MSB set: no predecessor
  logic signed [VAL_W-1:0] rb_mem [MAX_LEN];

  // Registered read data
  logic [IDX_W-1:0]        pt_rdata_q;
  logic signed [VAL_W-1:0] nv_rdata_q;
  logic [IDX_W:0]          bl_rdata_q;
  logic signed [VAL_W-1:0] rb_rdata_q;

  // Item and control registers
  logic signed [VAL_W-1:0] value_q;
  logic [CNT_W-1:0]        pile_cnt_q, node_cnt_q;
  logic [CNT_W-1:0]        lo_q, hi_q;
  logic [CNT_W-1:0]        walk_k_q, emit_k_q;

  // Output register
  logic [CNT_W-1:0]        seq_len_q;
  logic                    last_q;
  logic                    ovf_q;

  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        lo_m1, pile_m1, walk_m1;
  logic [IDX_W-1:0]        pt_raddr, nv_raddr;
  logic                    pt_ren, nv_ren;

  // Search midpoint and address arithmetic
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CNT_W:1];
  assign lo_m1   = lo_q - CNT_W'(1);
  assign pile_m1 = pile_cnt_q - CNT_W'(1);
  assign walk_m1 = walk_k_q - CNT_W'(1);

  // Pile top read address
  always_comb begin
    priority if (cmd_i.pt_rd_mid) begin
      pt_raddr = mid[IDX_W-1:0];
    end else if (cmd_i.pt_rd_link) begin
      pt_raddr = lo_m1[IDX_W-1:0];
    end else begin
      pt_raddr = pile_m1[IDX_W-1:0];
    end
  end
  assign pt_ren = cmd_i.pt_rd_mid | cmd_i.pt_rd_link | cmd_i.pt_rd_last;

  // Node store read address: follow the link while walking
  assign nv_raddr = cmd_i.walk_step ? bl_rdata_q[IDX_W-1:0] : pt_rdata_q;
  assign nv_ren   = cmd_i.nv_rd | cmd_i.walk_step;

  // Pile top table
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pt_mem[lo_q[IDX_W-1:0]] <= node_cnt_q[IDX_W-1:0];
    end
    if (pt_ren) begin
      pt_rdata_q <= pt_mem[pt_raddr];
    end
  end

  // Node store: value and back link
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      nv_mem[node_cnt_q[IDX_W-1:0]] <= value_q;
      bl_mem[node_cnt_q[IDX_W-1:0]] <= {(lo_q == '0), pt_rdata_q};
    end
    if (nv_ren) begin
      nv_rdata_q <= nv_mem[nv_raddr];
      bl_rdata_q <= bl_mem[nv_raddr];
    end
  end

  // Reverse buffer: filled back to front, read front to back
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      rb_mem[walk_m1[IDX_W-1:0]] <= nv_rdata_q;
    end
    if (cmd_i.emit_step) begin
      rb_rdata_q <= rb_mem[emit_k_q[IDX_W-1:0]];
    end
  end

  // Latch input value
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= in_value_i;
    end
  end

  // Counters and search window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pile_cnt_q <= '0;
      node_cnt_q <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      walk_k_q   <= '0;
      emit_k_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        lo_q <= '0;
        if (in_start_new_i) begin
          pile_cnt_q <= '0;
          node_cnt_q <= '0;
          hi_q       <= '0;
        end else begin
          hi_q <= pile_cnt_q;
        end
      end
      if (cmd_i.cmp_step) begin
        if (nv_rdata_q > value_q) begin
          hi_q <= mid;
        end else begin
          lo_q <= mid + CNT_W'(1);
        end
      end
      if (cmd_i.commit) begin
        node_cnt_q <= node_cnt_q + CNT_W'(1);
        if (lo_q == pile_cnt_q) begin
          pile_cnt_q <= pile_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.pt_rd_last) begin
        walk_k_q <= pile_cnt_q;
        emit_k_q <= '0;
      end
      if (cmd_i.walk_step) begin
        walk_k_q <= walk_m1;
      end
      if (cmd_i.emit_step) begin
        emit_k_q <= emit_k_q + CNT_W'(1);
      end
    end
  end

  // Output register fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      seq_len_q <= pile_cnt_q;
      last_q    <= sts_o.emit_last;
      ovf_q     <= 1'b0;
    end else if (cmd_i.ovf_load) begin
      seq_len_q <= pile_cnt_q;
      last_q    <= 1'b1;
      ovf_q     <= 1'b1;
    end
  end

  assign out_element_o    = ovf_q ? '0 : rb_rdata_q;
  assign out_seq_length_o = seq_len_q;
  assign out_last_o       = last_q;
  assign out_overflow_o   = ovf_q;

  // Status
  assign sts_o.full        = !in_start_new_i && (node_cnt_q >= CNT_W'(MAX_LEN));
  assign sts_o.search_open = (lo_q < hi_q);
  assign sts_o.walk_end    = bl_rdata_q[IDX_W] || (walk_k_q == CNT_W'(1));
  assign sts_o.emit_last   = ((emit_k_q + CNT_W'(1)) == pile_cnt_q);

endmodule

// ===== hw/rtl/lnds_chk.sv =====
// ============================================================================
// lnds_chk
// Port-level checker for the longest non-decreasing subsequence block,
// bound to the top level.
// ============================================================================
module lnds_chk import lnds_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [VAL_W-1:0] out_element_i,
  input logic [CNT_W-1:0]        out_seq_length_i,
  input logic                    out_last_i,
  input logic                    out_overflow_i
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_element_i) &&
    $stable(out_seq_length_i) && $stable(out_last_i) && $stable(out_overflow_i))
    else $error("result beat changed while stalled");

  // Overflow beat is a lone zero beat with piles present
  a_ovf_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_overflow_i |->
    out_last_i && (out_element_i == '0) && (out_seq_length_i != '0))
    else $error("malformed overflow beat");

  // Length is within the store
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_seq_length_i != '0) &&
    (out_seq_length_i <= CNT_W'(MAX_LEN)))
    else $error("seq_length out of range");

  // One item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on consecutive cycles");

  // Length stays fixed within a run
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
    out_seq_length_i == $past(out_seq_length_i))
    else $error("seq_length changed within a run");

endmodule

bind longest_nondecreasing_subsequence lnds_chk #(
  .MAX_LEN (MAX_LEN)
) u_lnds_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_element_i    (out_o.element),
  .out_seq_length_i (out_o.seq_length),
  .out_last_i       (out_o.last),
  .out_overflow_i   (out_o.overflow)
);

// ===== verif/longest_nondecreasing_subsequence_tb.sv =====
// ----------------------------------------------------------------------------
// longest_nondecreasing_subsequence_tb
// Streams signed values into the patience-sorting block and checks every
// result beat against a cycle-free predictor of the piles and node store.
// A directed opener hits value extremes, equal values and restarts. Random
// sequences follow, two of them long enough to fill the node store and
// trigger overflow. Both channels idle at random, and the result side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module longest_nondecreasing_subsequence_tb import lnds_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = MAX_LEN_DEF;
  localparam logic [6:0]  NO_PRED     = 7'h40;
  localparam int unsigned FEED_ITEMS  = 230;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_WAIT  = 300;
  // Worst case is roughly 230 items x 64 beats each; the limit leaves margin
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                    start_new;
    logic signed [VAL_W-1:0] value;
  } lnds_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    logic [CNT_W-1:0]        seq_length;
    logic                    last;
    logic                    overflow;
  } lnds_res_t;

  logic clk_i;
  logic rst_ni;

  lnds_in_if  in_if ();
  lnds_out_if out_if ();

  longest_nondecreasing_subsequence #(
    .MAX_LEN (MAX_LEN_DEF)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Pending input beats and expected subsequence beats
  lnds_beat_t value_feed_q[$];
  lnds_res_t  subseq_exp_q[$];

  // Predictor state: piles and node store
  int unsigned             pile_cnt;
  int unsigned             node_cnt;
  logic [5:0]              pile_top [DEPTH];
  logic signed [VAL_W-1:0] node_val [DEPTH];
  logic [6:0]              node_link [DEPTH];

  // Run bookkeeping
  int unsigned n_items;
  int unsigned n_beats;
  int unsigned n_overflow;
  int unsigned n_fail;
  int unsigned n_seq;
  int unsigned longest_run;
  int unsigned cycle_cnt;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned stall_cnt;
  logic        stall_done;
  logic        src_idle_on;
  logic        snk_idle_on;

  // Clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Drive every block input to a known value before the first edge
  initial begin
    in_if.valid     = 1'b0;
    in_if.start_new = 1'b0;
    in_if.value     = '0;
    out_if.ready    = 1'b0;
  end

  function automatic void queue_beat(input logic sn, input logic signed [VAL_W-1:0] v);
    lnds_beat_t b;
    b.start_new = sn;
    b.value     = v;
    value_feed_q = {value_feed_q, b};
    if (sn) n_seq++;
  endfunction

  // Place one value on the piles and queue the subsequence it yields
  function automatic void place_and_trace(input logic sn, input logic signed [VAL_W-1:0] v);
    int unsigned             lo, hi, mid, pos, node, cur, k, n;
    logic signed [VAL_W-1:0] chain [DEPTH];
    lnds_res_t               r;
    if (sn) begin
      pile_cnt = 0;
      node_cnt = 0;
    end
    // Store full: drop the value, answer with one overflow beat
    if (node_cnt >= DEPTH) begin
      r.element    = '0;
      r.seq_length = CNT_W'(pile_cnt);
      r.last       = 1'b1;
      r.overflow   = 1'b1;
      subseq_exp_q = {subseq_exp_q, r};
      n_overflow++;
      return;
    end
    // Find the first pile whose top is strictly greater than the value
    lo = 0;
    hi = pile_cnt;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (node_val[pile_top[mid]] > v) hi = mid;
      else lo = mid + 1;
    end
    pos  = lo;
    node = node_cnt;
    node_cnt++;
    node_val[node]  = v;
    node_link[node] = (pos != 0) ? {1'b0, pile_top[pos-1]} : NO_PRED;
    pile_top[pos]   = 6'(node);
    if (pos == pile_cnt) pile_cnt++;
    if (pile_cnt > longest_run) longest_run = pile_cnt;
    // Walk back from the last pile top, then emit in ascending order
    n   = pile_cnt;
    cur = pile_top[n-1];
    for (k = n; k > 0; k--) begin
      chain[k-1] = node_val[cur];
      if (node_link[cur][6]) break;
      cur = node_link[cur][5:0];
    end
    for (k = 0; k < n; k++) begin
      r.element    = chain[k];
      r.seq_length = CNT_W'(n);
      r.last       = (k + 1 == n);
      r.overflow   = 1'b0;
      subseq_exp_q = {subseq_exp_q, r};
    end
  endfunction

  // Input driver: present queued beats, idle between them as drawn
  always @(posedge clk_i or negedge rst_ni) begin : driver
    lnds_beat_t nxt;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.start_new <= 1'b0;
      in_if.value     <= '0;
      src_gap         <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (src_gap != 0) begin
        in_if.valid <= 1'b0;
        src_gap     <= src_gap - 1;
      end else if (value_feed_q.size() != 0) begin
        nxt = value_feed_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.start_new <= nxt.start_new;
        in_if.value     <= nxt.value;
        src_gap         <= src_idle_on ? $urandom_range(0, 15) : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls per beat, one long hold-off mid-run
  always @(posedge clk_i or negedge rst_ni) begin : sink
    int unsigned g;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap      <= 0;
      stall_cnt    <= 0;
      stall_done   <= 1'b0;
    end else if (stall_cnt != 0) begin
      out_if.ready <= (stall_cnt == 1);
      stall_cnt    <= stall_cnt - 1;
    end else if (!stall_done && n_items >= 100) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= HOLD_CYCLES;
      stall_done   <= 1'b1;
    end else if (out_if.valid && out_if.ready) begin
      g = snk_idle_on ? $urandom_range(0, 15) : 0;
      snk_gap      <= g;
      out_if.ready <= (g == 0);
    end else if (snk_gap != 0) begin
      out_if.ready <= (snk_gap == 1);
      snk_gap      <= snk_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: check result beats, predict on accepted input beats
  always @(posedge clk_i) begin : monitor
    lnds_res_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (subseq_exp_q.size() == 0) begin
          $error("result beat with nothing expected: element %0d", out_if.element);
          n_fail++;
        end else begin
          want = subseq_exp_q.pop_front();
          n_beats++;
          if (out_if.element !== want.element) begin
            $error("element: expected %0d, got %0d", want.element, out_if.element);
            n_fail++;
          end
          if (out_if.seq_length !== want.seq_length) begin
            $error("seq_length: expected %0d, got %0d", want.seq_length, out_if.seq_length);
            n_fail++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_if.last);
            n_fail++;
          end
          if (out_if.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_if.overflow);
            n_fail++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        place_and_trace(in_if.start_new, in_if.value);
        n_items <= n_items + 1;
        // Reshuffle idling every 30 beats; some stretches run flat out
        if ((n_items + 1) % 30 == 0) begin
          src_idle_on <= ($urandom_range(0, 2) != 0);
          snk_idle_on <= ($urandom_range(0, 2) != 0);
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("longest_nondecreasing_subsequence: mismatch");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin : run_ctl
    int unsigned             s, k, len, style;
    logic signed [VAL_W-1:0] v, prev;
    logic                    sn, is_long;
    rst_ni      = 1'b0;
    pile_cnt    = 0;
    node_cnt    = 0;
    n_items     = 0;
    n_beats     = 0;
    n_overflow  = 0;
    n_fail      = 0;
    n_seq       = 0;
    longest_run = 0;
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;

    // Directed: first beat straight after reset without a restart
    queue_beat(1'b0, 32'sd0);
    queue_beat(1'b0, VAL_MAX);
    queue_beat(1'b0, VAL_MIN);
    queue_beat(1'b0, VAL_MIN);
    queue_beat(1'b0, -32'sd1);
    queue_beat(1'b0, -32'sd1);
    queue_beat(1'b0, 32'sd0);
    queue_beat(1'b0, VAL_MAX);
    queue_beat(1'b0, VAL_MAX);
    // Restart mid-sequence, then equal values and replacements
    queue_beat(1'b1, VAL_MAX);
    queue_beat(1'b0, VAL_MIN);
    queue_beat(1'b0, 32'sd5);
    queue_beat(1'b0, 32'sd5);
    queue_beat(1'b0, 32'sd3);
    queue_beat(1'b0, 32'sd4);
    queue_beat(1'b0, 32'sd4);
    queue_beat(1'b0, 32'sd2);
    queue_beat(1'b0, 32'sh5555_5555);
    queue_beat(1'b0, 32'shAAAA_AAAA);
    queue_beat(1'b1, 32'sd1);

    // Random sequences; two long ones overflow the node store
    s = 0;
    while (value_feed_q.size() < FEED_ITEMS) begin
      is_long = (s == 1 || s == 8);
      len     = is_long ? $urandom_range(66, 70) : $urandom_range(1, 12);
      style   = is_long ? 2 : $urandom_range(0, 3);
      prev    = $urandom_range(0, 200) - 100;
      for (k = 0; k < len; k++) begin
        if (k == 0) sn = (s == 2 || s == 9) ? 1'b1 : ($urandom_range(0, 4) != 0);
        else sn = !is_long && ($urandom_range(0, 39) == 0);
        case (style)
          0: v = $urandom();
          1: v = $urandom_range(0, 8) - 4;
          2: begin
            v = prev + $urandom_range(0, 8) - 2;
            if ($urandom_range(0, 15) == 0) v = $urandom();
          end
          default: begin
            case ($urandom_range(0, 6))
              0: v = VAL_MIN;
              1: v = VAL_MIN + 1;
              2: v = VAL_MAX;
              3: v = VAL_MAX - 1;
              4: v = -32'sd1;
              5: v = 32'sd1;
              default: v = 32'sd0;
            endcase
          end
        endcase
        prev = v;
        queue_beat(sn, v);
      end
      s++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last input beat, then for all results, then settle
    while (value_feed_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (subseq_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (subseq_exp_q.size() != 0) begin
      $error("%0d expected result beats never arrived", subseq_exp_q.size());
      n_fail += subseq_exp_q.size();
    end
    $display("Ran %0d input beats over %0d restarts, checked %0d result beats.",
             n_items, n_seq, n_beats);
    $display("Saw %0d overflow beats; longest subsequence reached %0d.",
             n_overflow, longest_run);
    if (n_fail == 0) begin
      $display("longest_nondecreasing_subsequence: match");
    end else begin
      $display("longest_nondecreasing_subsequence: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lnds_pkg.sv
hw/rtl/lnds_if.sv
hw/rtl/lnds_ctrl.sv
hw/rtl/lnds_dp.sv
hw/rtl/longest_nondecreasing_subsequence.sv
hw/rtl/lnds_chk.sv
verif/longest_nondecreasing_subsequence_tb.sv
